// File: sv/hent_pkg.sv
// ----------------------------------------------------------------------------
// hent_pkg
// Shared types and constants of the histogram entropy core.
// ----------------------------------------------------------------------------
package hent_pkg;

  // log2 mantissa is Q1.30
  localparam int MANT_FRAC = 30;
  localparam int MANT_W    = MANT_FRAC + 1;

  // fixed field widths on the stream ports
  localparam int COUNT_FIELD_W = 16;
  localparam int ENT_W         = 18;
  localparam int TOTAL_W       = 19;
  localparam int STATUS_W      = 2;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 40;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic capture;        // take the input count into the accumulators
    logic log_start;      // launch the log2 unit
    logic log_sel_total;  // log2 operand: 1 = running total, 0 = input count
    logic mul;            // register count * log2(count)
    logic acc;            // add the product into the weighted sum
    logic div_start;      // launch weighted sum / total
    logic finish;         // load the result register and clear the state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_log;   // input count is taken and greater than one
    logic last_in;    // tlast of the input on the port
    logic last_r;     // tlast of the captured count
    logic log_done;
    logic div_done;
    logic skip;       // overflow or empty histogram: no arithmetic needed
    logic out_free;   // result register can take a new result this cycle
  } stat_t;

endpackage

// File: sv/hent_log2.sv
// ----------------------------------------------------------------------------
// hent_log2
// Iterative fixed-point log2: normalize one bit per cycle, then one
// mantissa squaring per fraction bit.
// ----------------------------------------------------------------------------
module hent_log2 #(
  parameter int IN_W   = 19,
  parameter int FRAC_W = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [IN_W-1:0]                 x,
  output logic                            done,
  output logic [$clog2(IN_W)+FRAC_W-1:0]  result
);
  import hent_pkg::*;

  localparam int E_W   = $clog2(IN_W);
  localparam int CNT_W = $clog2(FRAC_W);

  logic [MANT_W-1:0]   m_r, m_nxt;
  logic [E_W-1:0]      e_r, e_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                norm_r, norm_nxt;
  logic                done_r, done_nxt;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq_sh;
  logic                last_iter;

  assign sq        = m_r * m_r;
  assign sq_sh     = sq[2*MANT_W-1:MANT_FRAC];
  assign last_iter = (cnt_r == CNT_W'(FRAC_W - 1));

  always_comb begin
    m_nxt    = m_r;
    e_nxt    = e_r;
    frac_nxt = frac_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    norm_nxt = norm_r;
    done_nxt = 1'b0;
    if (start) begin
      // operand's top bit lands on the mantissa's integer bit
      m_nxt    = MANT_W'(x) << (MANT_W - IN_W);
      e_nxt    = E_W'(IN_W - 1);
      frac_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      norm_nxt = 1'b1;
    end else if (busy_r && norm_r) begin
      if (m_r[MANT_W-1]) begin
        norm_nxt = 1'b0;
      end else begin
        m_nxt = m_r << 1;
        e_nxt = e_r - 1'b1;
      end
    end else if (busy_r) begin
      m_nxt    = sq_sh[MANT_W] ? sq_sh[MANT_W:1] : sq_sh[MANT_W-1:0];
      frac_nxt = {frac_r[FRAC_W-2:0], sq_sh[MANT_W]};
      cnt_nxt  = cnt_r + 1'b1;
      if (last_iter) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      norm_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      norm_r <= norm_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    e_r    <= e_nxt;
    frac_r <= frac_nxt;
  end

  assign done   = done_r;
  assign result = {e_r, frac_r};

endmodule

// File: sv/hent_div.sv
// ----------------------------------------------------------------------------
// hent_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hent_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 19
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  import hent_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: sv/hent_datapath.sv
// ----------------------------------------------------------------------------
// hent_datapath
// Accumulators, log2 and divide units, final entropy and result register.
// ----------------------------------------------------------------------------
module hent_datapath #(
  parameter int MAX_CLASSES = 8,
  parameter int COUNT_BITS  = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [COUNT_BITS-1:0]          count_in,
  input  logic                           last_in,
  input  hent_pkg::cmd_t                 cmd,
  output hent_pkg::stat_t                st,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [hent_pkg::ENT_W-1:0]     out_entropy,
  output logic [hent_pkg::TOTAL_W-1:0]   out_total,
  output logic [hent_pkg::STATUS_W-1:0]  out_status
);
  import hent_pkg::*;

  localparam int SEEN_W = $clog2(MAX_CLASSES + 1);
  localparam int TOT_W  = COUNT_BITS + $clog2(MAX_CLASSES);
  localparam int LOG_W  = $clog2(TOT_W) + FRAC_BITS;
  localparam int PROD_W = COUNT_BITS + LOG_W;
  localparam int WSUM_W = PROD_W + $clog2(MAX_CLASSES);
  localparam logic [WSUM_W-1:0] CAP = WSUM_W'($clog2(MAX_CLASSES)) << FRAC_BITS;

  logic [TOT_W-1:0]      total_r;
  logic [WSUM_W-1:0]     wsum_r;
  logic [SEEN_W-1:0]     seen_r;
  logic                  ovf_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  last_r;
  logic [PROD_W-1:0]     prod_r;
  logic                  out_valid_r;
  logic [ENT_W-1:0]      out_ent_r;
  logic [TOTAL_W-1:0]    out_tot_r;
  logic [STATUS_W-1:0]   out_stat_r;

  logic                  room;
  logic [TOT_W-1:0]      log_x;
  logic                  log_done;
  logic [LOG_W-1:0]      log_res;
  logic                  div_done;
  logic [WSUM_W-1:0]     quo;
  logic [WSUM_W-1:0]     ls_ext;
  logic [WSUM_W-1:0]     ent_raw;
  logic [WSUM_W-1:0]     ent_cap;
  logic [ENT_W-1:0]      ent_nxt;
  logic [STATUS_W-1:0]   stat_nxt;

  assign room  = (seen_r < SEEN_W'(MAX_CLASSES));
  assign log_x = cmd.log_sel_total ? total_r : TOT_W'(count_in);

  hent_log2 #(
    .IN_W   (TOT_W),
    .FRAC_W (FRAC_BITS)
  ) u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  hent_div #(
    .NUM_W (WSUM_W),
    .DEN_W (TOT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (wsum_r),
    .den   (total_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    ls_ext  = WSUM_W'(log_res);
    ent_raw = (ls_ext > quo) ? (ls_ext - quo) : '0;
    ent_cap = (ent_raw > CAP) ? CAP : ent_raw;
    if (ovf_r) begin
      stat_nxt = STATUS_OVERFLOW;
      ent_nxt  = '0;
    end else if (total_r == '0) begin
      stat_nxt = STATUS_EMPTY;
      ent_nxt  = '0;
    end else begin
      stat_nxt = STATUS_OK;
      ent_nxt  = ENT_W'(ent_cap);
    end
  end

  always_comb begin
    st.need_log = room && (count_in > COUNT_BITS'(1));
    st.last_in  = last_in;
    st.last_r   = last_r;
    st.log_done = log_done;
    st.div_done = div_done;
    st.skip     = ovf_r || (total_r == '0);
    st.out_free = !out_valid_r || out_ready;
  end

  // accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      total_r <= '0;
      wsum_r  <= '0;
      seen_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.capture) begin
        if (room) begin
          total_r <= total_r + TOT_W'(count_in);
          seen_r  <= seen_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.acc) begin
        wsum_r <= wsum_r + WSUM_W'(prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cnt_r  <= count_in;
      last_r <= last_in;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(cnt_r) * PROD_W'(log_res);
    end
    if (cmd.finish) begin
      out_ent_r  <= ent_nxt;
      out_tot_r  <= TOTAL_W'(total_r);
      out_stat_r <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_entropy = out_ent_r;
  assign out_total   = out_tot_r;
  assign out_status  = out_stat_r;

endmodule

// File: sv/hent_ctrl.sv
// ----------------------------------------------------------------------------
// hent_ctrl
// Sequencer: per-count log/multiply/accumulate, then per-histogram
// log of the total, divide and result load.
// ----------------------------------------------------------------------------
module hent_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  hent_pkg::stat_t st,
  output hent_pkg::cmd_t  cmd
);
  import hent_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOG_C  = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_ACC    = 8'b0000_1000,
    S_CHECK  = 8'b0001_0000,
    S_LOG_S  = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // no transfer is taken while reset is held
  assign in_ready = rst_n && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (st.need_log) begin
            cmd.log_start = 1'b1;
            state_nxt     = S_LOG_C;
          end else if (st.last_in) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_LOG_C: begin
        if (st.log_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = st.last_r ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (st.skip) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.log_start     = 1'b1;
          cmd.log_sel_total = 1'b1;
          state_nxt         = S_LOG_S;
        end
      end
      S_LOG_S: begin
        cmd.log_sel_total = 1'b1;
        if (st.log_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the result register is free
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/histogram_entropy_core.sv
// ----------------------------------------------------------------------------
// histogram_entropy_core
// Base-2 Shannon entropy of a histogram streamed one class count per transfer.
//
//   channel  dir  data                                        marker
//   in_      in   [15:0] count                                tlast = last count
//   out_     out  [17:0] entropy_q16, [36:18] total,          -
//                 [38:37] status, [39] zero
//
// A count of 0 or 1 is only captured. A larger count runs the shared log2 unit:
// normalize shifts, one mantissa squaring per fraction bit, then multiply and
// accumulate. Unless the histogram is empty or over the class limit, a last
// count adds a log2 of the total plus the bit-serial divide of the weighted sum
// (40 bits wide at the defaults) before the result load. Synchronous reset
// clears control and the accumulators. A waiting result does not block input
// until the next result is ready to load.
// ----------------------------------------------------------------------------
module histogram_entropy_core #(
  parameter int MAX_CLASSES = 8,
  parameter int COUNT_BITS  = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hent_pkg::IN_DATA_W-1:0]    in_tdata,   // [15:0] count
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hent_pkg::OUT_DATA_W-1:0]   out_tdata   // [17:0] entropy_q16,
                                                        // [36:18] total,
                                                        // [38:37] status
);
  import hent_pkg::*;

  cmd_t                  cmd;
  stat_t                 st;
  logic [ENT_W-1:0]      entropy;
  logic [TOTAL_W-1:0]    total;
  logic [STATUS_W-1:0]   status;
  logic [COUNT_BITS-1:0] count;

  assign count = COUNT_BITS'(in_tdata[COUNT_FIELD_W-1:0]);

  hent_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  hent_datapath #(
    .MAX_CLASSES (MAX_CLASSES),
    .COUNT_BITS  (COUNT_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .count_in    (count),
    .last_in     (in_tlast),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_entropy (entropy),
    .out_total   (total),
    .out_status  (status)
  );

  assign out_tdata = OUT_DATA_W'({status, total, entropy});

endmodule

// File: dv/histogram_entropy_core_tb.sv
// ----------------------------------------------------------------------------
// histogram_entropy_core_tb
// Streams histograms into the entropy core and checks every result against
// an in-bench fixed-point entropy calculator. A short directed set covers
// empty, single-class, full-scale and too-many-counts histograms. Random
// histograms follow, with random gaps on both sides and one long result
// stall that backs the core up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module histogram_entropy_core_tb;
  import hent_pkg::*;

  localparam int MAX_CLASSES  = 8;
  localparam int COUNT_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int LOG_MANT     = 30;
  localparam int NUM_ITEMS    = 1500;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int HOLD_AT_XFER = 300;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [COUNT_FIELD_W-1:0] count;
    logic                     last;
  } count_item_t;

  typedef struct {
    logic [ENT_W-1:0]    entropy;
    logic [TOTAL_W-1:0]  total;
    logic [STATUS_W-1:0] status;
  } entropy_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  count_item_t     pending_counts[$];
  entropy_result_t expected_results[$];

  // predictor state
  logic [63:0] hist_total;
  logic [63:0] hist_wlog;
  int          hist_classes;
  logic        hist_overflow;

  int mismatches  = 0;
  int in_xfers    = 0;
  int results_ok  = 0;
  int n_hists     = 0;
  int n_ovf_hists = 0;
  int n_empty     = 0;
  int idle_cycles = 0;

  int          in_gap;
  int          in_calm;
  int          out_gap;
  int          out_calm;
  int          hold_left;
  logic        hold_done;
  count_item_t drv_item;

  histogram_entropy_core #(
    .MAX_CLASSES(MAX_CLASSES),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // log2 in fixed point by repeated squaring of a Q1.30 mantissa
  function automatic logic [63:0] log2_q(input logic [63:0] x);
    int          msb;
    logic [63:0] mant;
    logic [63:0] frac;
    if (x == 0) return 64'd0;
    msb = 0;
    while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
    if (msb <= LOG_MANT) mant = x << (LOG_MANT - msb);
    else mant = x >> (msb - LOG_MANT);
    frac = 0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      mant = (mant * mant) >> LOG_MANT;
      frac = frac << 1;
      if (mant >= (64'd1 << (LOG_MANT + 1))) begin
        mant = mant >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(msb) << FRAC_BITS) | frac;
  endfunction

  function automatic void clear_hist();
    hist_total    = 0;
    hist_wlog     = 0;
    hist_classes  = 0;
    hist_overflow = 1'b0;
  endfunction

  // fold one accepted count into the running histogram; close it on last
  function automatic void accumulate_count(input logic [COUNT_FIELD_W-1:0] cnt_in,
                                           input logic last);
    logic [63:0]     c;
    logic [63:0]     ls;
    logic [63:0]     q;
    logic [63:0]     ent;
    logic [63:0]     cap;
    entropy_result_t r;
    c = 64'(cnt_in) & ((64'd1 << COUNT_BITS) - 1);
    if (hist_classes < MAX_CLASSES) begin
      hist_total = hist_total + c;
      if (c > 1) hist_wlog = hist_wlog + c * log2_q(c);
      hist_classes++;
    end else begin
      hist_overflow = 1'b1;
    end
    if (!last) return;
    ent = 0;
    if (hist_overflow) begin
      r.status = STATUS_OVERFLOW;
    end else if (hist_total == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.status = STATUS_OK;
      ls  = log2_q(hist_total);
      q   = hist_wlog / hist_total;
      cap = 64'($clog2(MAX_CLASSES)) << FRAC_BITS;
      ent = (ls > q) ? ls - q : 64'd0;
      if (ent > cap) ent = cap;
    end
    r.entropy = ent[ENT_W-1:0];
    r.total   = hist_total[TOTAL_W-1:0];
    expected_results.push_back(r);
    clear_hist();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic push_count(input logic [COUNT_FIELD_W-1:0] c, input logic last);
    count_item_t it;
    it.count = c;
    it.last  = last;
    pending_counts.push_back(it);
  endtask

  function automatic logic [COUNT_FIELD_W-1:0] random_count();
    int mode;
    mode = $urandom_range(0, 3);
    case (mode)
      0: return COUNT_FIELD_W'($urandom_range(0, 3));
      1: return COUNT_FIELD_W'($urandom_range(0, 255));
      2: return COUNT_FIELD_W'($urandom_range(0, 65535));
      default: return COUNT_FIELD_W'(1) << $urandom_range(0, COUNT_FIELD_W - 1);
    endcase
  endfunction

  // driver: one item per transfer, fed from pending_counts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap  = 0;
      in_calm = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        accumulate_count(in_tdata[COUNT_FIELD_W-1:0], in_tlast);
        in_xfers <= in_xfers + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0 || pending_counts.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_tvalid <= 1'b0;
        end else begin
          drv_item = pending_counts.pop_front();
          in_tdata  <= drv_item.count;
          in_tlast  <= drv_item.last;
          in_tvalid <= 1'b1;
          if (in_calm > 0) begin
            in_calm--;
            in_gap = 0;
          end else begin
            in_gap = pick_gap();
            if ($urandom_range(0, 149) == 0) in_calm = 40;
          end
        end
      end
    end
  end

  // receiver backpressure, with one long hold-off once traffic is going
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap   = 0;
      out_calm  = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && in_xfers >= HOLD_AT_XFER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_calm > 0) begin
          out_calm--;
        end else begin
          if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
          if ($urandom_range(0, 199) == 0) out_calm = 60;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    entropy_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: tdata=%h", out_tdata);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata[17:0] !== exp_r.entropy) begin
          $error("entropy_q16: expected %0d, actual %0d", exp_r.entropy, out_tdata[17:0]);
          mismatches++;
        end
        if (out_tdata[36:18] !== exp_r.total) begin
          $error("total: expected %0d, actual %0d", exp_r.total, out_tdata[36:18]);
          mismatches++;
        end
        if (out_tdata[38:37] !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_tdata[38:37]);
          mismatches++;
        end
        results_ok++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d cycles without a transfer", idle_cycles);
      $display("[histogram_entropy_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    int r;
    int n_items;
    clear_hist();

    // directed: empty, single classes at the extremes, equal split
    push_count(16'd0, 1'b1);
    push_count(16'd1, 1'b1);
    push_count(16'hFFFF, 1'b1);
    push_count(16'd5, 1'b0);
    push_count(16'd5, 1'b1);
    // every class full scale: largest total, entropy at the cap
    for (int i = 0; i < MAX_CLASSES; i++) push_count(16'hFFFF, i == MAX_CLASSES - 1);
    // one count more than the class limit
    for (int i = 0; i <= MAX_CLASSES; i++)
      push_count(COUNT_FIELD_W'($urandom_range(2, 1000)), i == MAX_CLASSES);
    // zero counts mixed in
    push_count(16'd0, 1'b0);
    push_count(16'd7, 1'b0);
    push_count(16'd0, 1'b1);
    n_hists     = 7;
    n_ovf_hists = 1;
    n_empty     = 1;

    // random histograms, mostly well formed
    n_items = pending_counts.size();
    while (n_items < NUM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        len = $urandom_range(1, MAX_CLASSES);
        for (int i = 0; i < len; i++) push_count(random_count(), i == len - 1);
      end else if (r < 93) begin
        len = $urandom_range(MAX_CLASSES + 1, MAX_CLASSES + 4);
        for (int i = 0; i < len; i++) push_count(random_count(), i == len - 1);
        n_ovf_hists++;
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) push_count(16'd0, i == len - 1);
        n_empty++;
      end
      n_hists++;
      n_items += len;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_counts.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    $display("covered %0d histograms from %0d count transfers, %0d results checked",
             n_hists, in_xfers, results_ok);
    $display("  including %0d over the class limit and %0d all-zero, plus one long stall",
             n_ovf_hists, n_empty);
    if (mismatches == 0) begin
      $display("[histogram_entropy_core] OK");
    end else begin
      $display("[histogram_entropy_core] ERROR");
    end
    $finish;
  end

endmodule
